/* rtl/core/rv32_load_store_unit_macros.svh */
// Assertion macros used by the load/store unit RTL.
`ifndef RV32_LOAD_STORE_UNIT_MACROS_SVH
`define RV32_LOAD_STORE_UNIT_MACROS_SVH

`ifndef SYNTH
`define RV32LSU_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rv32lsu: same-cycle check failed");
`define RV32LSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rv32lsu: next-cycle check failed");
`else
`define RV32LSU_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RV32LSU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/rv32lsu_pkg.sv */
// Types, codes and helper functions of the RV32I load/store unit.
package rv32lsu_pkg;

  localparam int unsigned TAG_WIDTH = 6;

  typedef enum logic [3:0] {
    KIND_NONE = 4'd0,
    KIND_LB   = 4'd1,
    KIND_LH   = 4'd2,
    KIND_LW   = 4'd3,
    KIND_LBU  = 4'd4,
    KIND_LHU  = 4'd5,
    KIND_SB   = 4'd6,
    KIND_SH   = 4'd7,
    KIND_SW   = 4'd8
  } op_kind_t;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2
  } size_code_t;

  typedef enum logic [1:0] {
    STALL_NONE       = 2'd0,
    STALL_DATA       = 2'd1,
    STALL_MEM        = 2'd2,
    STALL_MISALIGNED = 2'd3
  } stall_cause_t;

  typedef struct packed {
    logic [3:0]           op_kind;
    logic [31:0]          op_addr;
    logic [TAG_WIDTH-1:0] op_tag;
    logic [4:0]           op_store_reg;
    logic                 op_store_ready;
    logic [31:0]          op_store_data;
    logic                 wb_valid;
    logic [4:0]           wb_reg;
    logic [31:0]          wb_value;
    logic                 mem_done;
    logic [31:0]          mem_rdata;
    logic                 out_taken;
  } in_t;

  typedef struct packed {
    logic                 out_valid;
    logic [TAG_WIDTH-1:0] out_tag;
    logic [31:0]          out_value;
    logic [31:0]          out_store_data;
    logic [1:0]           out_size_code;
    logic                 req_valid;
    logic                 req_write;
    logic [31:0]          req_addr;
    logic [1:0]           req_size_code;
    logic [31:0]          req_wdata;
    logic [1:0]           stall_cause;
    logic                 op_accepted;
  } out_t;

  function automatic logic kind_is_store(logic [3:0] k);
    return (k == KIND_SB) || (k == KIND_SH) || (k == KIND_SW);
  endfunction

  function automatic logic kind_is_valid(logic [3:0] k);
    return (k >= KIND_LB) && (k <= KIND_SW);
  endfunction

  function automatic logic [1:0] kind_size(logic [3:0] k);
    logic [1:0] sz;
    case (k)
      KIND_LB, KIND_LBU, KIND_SB: sz = SIZE_BYTE;
      KIND_LH, KIND_LHU, KIND_SH: sz = SIZE_HALF;
      default: sz = SIZE_WORD;
    endcase
    return sz;
  endfunction

endpackage

/* rtl/core/rv32lsu_step.sv */
// Slot state of the load/store unit and the logic of one tick.
`include "rv32_load_store_unit_macros.svh"

module rv32lsu_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  rv32lsu_pkg::in_t   item,
  output rv32lsu_pkg::out_t  step_res
);

  typedef struct packed {
    logic                              addr_valid;
    logic [3:0]                        addr_kind;
    logic [31:0]                       addr_addr;
    logic [rv32lsu_pkg::TAG_WIDTH-1:0] addr_tag;
    logic [4:0]                        addr_store_reg;
    logic                              addr_data_ready;
    logic [31:0]                       addr_store_data;
    logic                              acc_valid;
    logic [3:0]                        acc_kind;
    logic [31:0]                       acc_value;
    logic [rv32lsu_pkg::TAG_WIDTH-1:0] acc_tag;
    logic [4:0]                        acc_store_reg;
    logic                              acc_data_ready;
    logic [31:0]                       acc_store_data;
    logic                              access_pending;
    logic                              access_finished;
    logic                              out_valid;
    logic [rv32lsu_pkg::TAG_WIDTH-1:0] out_tag;
    logic [31:0]                       out_value;
    logic [31:0]                       out_store_data;
    logic [1:0]                        out_size;
  } slot_state_t;

  slot_state_t st;
  slot_state_t st_next;

  function automatic slot_state_t complete_access(slot_state_t s, logic [31:0] rdata);
    slot_state_t r;
    r = s;
    case (s.acc_kind)
      rv32lsu_pkg::KIND_LB:  r.acc_value = {{24{rdata[7]}}, rdata[7:0]};
      rv32lsu_pkg::KIND_LBU: r.acc_value = {24'd0, rdata[7:0]};
      rv32lsu_pkg::KIND_LH:  r.acc_value = {{16{rdata[15]}}, rdata[15:0]};
      rv32lsu_pkg::KIND_LHU: r.acc_value = {16'd0, rdata[15:0]};
      rv32lsu_pkg::KIND_LW:  r.acc_value = rdata;
      rv32lsu_pkg::KIND_SB:  r.acc_store_data = {24'd0, s.acc_store_data[7:0]};
      rv32lsu_pkg::KIND_SH:  r.acc_store_data = {16'd0, s.acc_store_data[15:0]};
      default: ;
    endcase
    r.access_pending  = 1'b0;
    r.access_finished = 1'b1;
    return r;
  endfunction

  function automatic slot_state_t clear_acc(slot_state_t s);
    slot_state_t r;
    r = s;
    r.acc_valid      = 1'b0;
    r.acc_kind       = rv32lsu_pkg::KIND_NONE;
    r.acc_value      = '0;
    r.acc_tag        = '0;
    r.acc_store_reg  = '0;
    r.acc_data_ready = 1'b0;
    r.acc_store_data = '0;
    return r;
  endfunction

  function automatic slot_state_t drain(slot_state_t s);
    slot_state_t r;
    r = s;
    if (s.acc_valid && s.access_finished && !s.out_valid) begin
      r.out_valid      = 1'b1;
      r.out_tag        = s.acc_tag;
      r.out_value      = s.acc_value;
      r.out_store_data = rv32lsu_pkg::kind_is_store(s.acc_kind) ? s.acc_store_data : '0;
      r.out_size       = rv32lsu_pkg::kind_size(s.acc_kind);
      r                = clear_acc(r);
      r.access_finished = 1'b0;
    end
    return r;
  endfunction

  logic       done_used;
  logic       acc_store;
  logic [1:0] acc_size;
  logic       misaligned;

  always_comb begin
    st_next   = st;
    step_res  = '0;
    done_used = 1'b0;
    acc_store = 1'b0;
    acc_size  = rv32lsu_pkg::SIZE_BYTE;
    misaligned = 1'b0;
    step_res.stall_cause = rv32lsu_pkg::STALL_NONE;

    if (item.out_taken) begin
      st_next.out_valid = 1'b0;
    end

    // capture forwarded store data
    if (item.wb_valid) begin
      if (st_next.addr_valid && rv32lsu_pkg::kind_is_store(st_next.addr_kind) &&
          !st_next.addr_data_ready && st_next.addr_store_reg == item.wb_reg) begin
        st_next.addr_store_data = item.wb_value;
        st_next.addr_data_ready = 1'b1;
      end
      if (st_next.acc_valid && rv32lsu_pkg::kind_is_store(st_next.acc_kind) &&
          !st_next.acc_data_ready && st_next.acc_store_reg == item.wb_reg) begin
        st_next.acc_store_data = item.wb_value;
        st_next.acc_data_ready = 1'b1;
      end
    end

    if (st_next.acc_valid && st_next.access_pending) begin
      if (item.mem_done) begin
        st_next   = complete_access(st_next, item.mem_rdata);
        done_used = 1'b1;
      end else begin
        step_res.stall_cause = rv32lsu_pkg::STALL_MEM;
      end
    end

    st_next = drain(st_next);

    // advance address slot into access slot
    if (!st_next.acc_valid && st_next.addr_valid) begin
      st_next.acc_valid       = 1'b1;
      st_next.acc_kind        = st_next.addr_kind;
      st_next.acc_value       = st_next.addr_addr;
      st_next.acc_tag         = st_next.addr_tag;
      st_next.acc_store_reg   = st_next.addr_store_reg;
      st_next.acc_data_ready  = st_next.addr_data_ready;
      st_next.acc_store_data  = st_next.addr_store_data;
      st_next.access_pending  = 1'b0;
      st_next.access_finished = 1'b0;
      st_next.addr_valid      = 1'b0;
      st_next.addr_kind       = rv32lsu_pkg::KIND_NONE;
      st_next.addr_addr       = '0;
      st_next.addr_tag        = '0;
      st_next.addr_store_reg  = '0;
      st_next.addr_data_ready = 1'b0;
      st_next.addr_store_data = '0;
    end

    if (st_next.acc_valid && !st_next.access_pending && !st_next.access_finished) begin
      acc_store  = rv32lsu_pkg::kind_is_store(st_next.acc_kind);
      acc_size   = rv32lsu_pkg::kind_size(st_next.acc_kind);
      misaligned = ((acc_size == rv32lsu_pkg::SIZE_HALF) && st_next.acc_value[0]) ||
                   ((acc_size == rv32lsu_pkg::SIZE_WORD) && (st_next.acc_value[1:0] != 2'd0));
      if (acc_store && !st_next.acc_data_ready) begin
        step_res.stall_cause = rv32lsu_pkg::STALL_DATA;
      end else if (misaligned) begin
        step_res.stall_cause = rv32lsu_pkg::STALL_MISALIGNED;
        st_next = clear_acc(st_next);
      end else begin
        step_res.req_valid     = 1'b1;
        step_res.req_write     = acc_store;
        step_res.req_addr      = st_next.acc_value;
        step_res.req_size_code = acc_size;
        step_res.req_wdata     = acc_store ? st_next.acc_store_data : '0;
        st_next.access_pending = 1'b1;
        if (item.mem_done && !done_used) begin
          st_next = complete_access(st_next, item.mem_rdata);
        end else begin
          step_res.stall_cause = rv32lsu_pkg::STALL_MEM;
        end
      end
    end

    st_next = drain(st_next);

    if (!st_next.addr_valid && rv32lsu_pkg::kind_is_valid(item.op_kind)) begin
      st_next.addr_valid      = 1'b1;
      st_next.addr_kind       = item.op_kind;
      st_next.addr_addr       = item.op_addr;
      st_next.addr_tag        = item.op_tag;
      st_next.addr_store_reg  = item.op_store_reg;
      st_next.addr_data_ready = item.op_store_ready;
      st_next.addr_store_data = item.op_store_ready ? item.op_store_data : '0;
      step_res.op_accepted    = 1'b1;
    end

    step_res.out_valid      = st_next.out_valid;
    step_res.out_tag        = st_next.out_tag;
    step_res.out_value      = st_next.out_value;
    step_res.out_store_data = st_next.out_store_data;
    step_res.out_size_code  = st_next.out_size;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  `RV32LSU_ASSERT_IMPL(a_pending_has_slot, clk, rst, st.access_pending, st.acc_valid)
  `RV32LSU_ASSERT_IMPL(a_pending_not_done, clk, rst, st.access_pending, !st.access_finished)
  `RV32LSU_ASSERT_IMPL(a_req_stall, clk, rst, step_res.req_valid, (step_res.stall_cause == rv32lsu_pkg::STALL_NONE) || (step_res.stall_cause == rv32lsu_pkg::STALL_MEM))
  `RV32LSU_ASSERT_IMPL(a_req_aligned, clk, rst, step_res.req_valid && (step_res.req_size_code != rv32lsu_pkg::SIZE_BYTE), !step_res.req_addr[0] && ((step_res.req_size_code != rv32lsu_pkg::SIZE_WORD) || !step_res.req_addr[1]))
  `RV32LSU_ASSERT_NEXT(a_accept_fills, clk, rst, advance && step_res.op_accepted, st.addr_valid)

endmodule

/* rtl/core/rv32lsu_out_reg.sv */
// Result register between the tick logic and the result channel.
module rv32lsu_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load_valid,
  output logic               load_ready,
  input  rv32lsu_pkg::out_t  load_data,
  output logic               res_valid,
  input  logic               res_ready,
  output rv32lsu_pkg::out_t  res_data
);

  assign load_ready = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_ready) begin
      res_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      res_data <= load_data;
    end
  end

endmodule

/* rtl/core/rv32_load_store_unit.sv */
// RV32I load/store unit: one input word is one clock tick of the three-slot
// unit (address, access, output) and yields exactly one result word. The block
// takes one word per clock cycle; a word passes through an input register,
// the tick logic that updates the slot registers, and a result register in
// front of the result channel. The sustained rate of one word per cycle holds
// while the result side keeps taking words; when it stalls, the result
// register and then the input register fill and in_ready falls.
module rv32_load_store_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rv32lsu_pkg::in_t   in_data,
  output logic               res_valid,
  input  logic               res_ready,
  output rv32lsu_pkg::out_t  res_data
);

  logic              in_q_valid;
  rv32lsu_pkg::in_t  in_q;
  logic              load_ready;
  logic              advance;
  rv32lsu_pkg::out_t step_res;

  assign advance  = in_q_valid && load_ready;
  assign in_ready = !in_q_valid || load_ready;

  // hold the word until the tick logic takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  rv32lsu_step u_step (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .item     (in_q),
    .step_res (step_res)
  );

  rv32lsu_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (in_q_valid),
    .load_ready (load_ready),
    .load_data  (step_res),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
  );

endmodule
